### hdl/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package mlfq_pkg;

    localparam int ID_W   = 6;
    localparam int MODE_W = 2;
    localparam int LVL_W  = 2;
    localparam int PRIO_W = 4;
    localparam int QNT_W  = 4;

    localparam int PROC_SLOTS_DEF = 64;
    localparam int AGE_WIDTH_DEF  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADMIT = 2'd0,
        MODE_ENQ   = 2'd1,
        MODE_DEQ   = 2'd2,
        MODE_BOOST = 2'd3
    } t_mode;

    localparam logic [LVL_W-1:0] LVL_0    = 2'd0;
    localparam logic [LVL_W-1:0] LVL_1    = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HEAP = 2'd2;

    localparam logic [QNT_W-1:0] QNT_L0 = 4'd4;
    localparam logic [QNT_W-1:0] QNT_L1 = 4'd6;
    localparam logic [QNT_W-1:0] QNT_L2 = 4'd8;

    typedef enum logic [2:0] {
        CTX_ENQ,
        CTX_DEQ,
        CTX_B0,
        CTX_B1,
        CTX_B2
    } t_ctx;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_ADM_WR, S_ENQ_RD, S_ENQ_WR, S_RPUSH, S_HPUSH,
        S_RB_INIT, S_RB_NEXT, S_SD_CHK, S_SD_IK, S_SD_L, S_SD_LK, S_SD_LC,
        S_SD_R, S_SD_RK, S_SD_RC, S_SD_X, S_SD_Y, S_HP_A, S_HP_B, S_HP_C,
        S_RP_A, S_RP_B, S_DQ_RD, S_DQ_WR, S_B0_A, S_B0_B, S_BST_RD, S_BST_WR,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_DISP, OP_ADM_WR, OP_ENQ_RD, OP_ENQ_WR, OP_RPUSH, OP_HPUSH,
        OP_RB_INIT, OP_RB_NEXT, OP_SD_CHK, OP_SD_IK, OP_SD_L, OP_SD_LK, OP_SD_LC,
        OP_SD_R, OP_SD_RK, OP_SD_RC, OP_SD_X, OP_SD_Y, OP_HP_A, OP_HP_B, OP_HP_C,
        OP_RP_A, OP_RP_B, OP_DQ_RD, OP_DQ_WR, OP_B0_A, OP_B0_B, OP_BST_RD,
        OP_BST_WR, OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ring;     // ring to pop from
    } t_cmd;

    typedef struct packed {
        t_mode            mode;
        logic             pid_ok;
        logic             run;
        logic [LVL_W-1:0] lvl;
        logic             enq_heap;
        logic [1:0]       ring_empty;
        logic             heap_empty;
        logic             sd_leaf;
        logic             sd_has_r;
        logic             sd_same;
        logic             rb_zero;
        logic             walk_end;
        logic             out_free;
    } t_stat;

endpackage

`default_nettype wire

### hdl/mlfq_in_if.sv
// Request channel of the scheduler: valid/ready plus one request word.
// Depends on mlfq_pkg for field widths.
`default_nettype none

interface mlfq_in_if import mlfq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   proc_id;
    logic              runnable;
    logic [LVL_W-1:0]  level;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, mode, proc_id, runnable, level, priority_req,
                    input ready);
    modport sink   (input valid, mode, proc_id, runnable, level, priority_req,
                    output ready);
endinterface

`default_nettype wire

### hdl/mlfq_out_if.sv
// Result channel of the scheduler: valid/ready plus one result word.
// Depends on mlfq_pkg for field widths.
`default_nettype none

interface mlfq_out_if import mlfq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [ID_W-1:0]  chosen_id;
    logic [QNT_W-1:0] ticks_left;
    logic [LVL_W-1:0] chosen_level;

    modport source (output valid, found, chosen_id, ticks_left, chosen_level,
                    input ready);
    modport sink   (input valid, found, chosen_id, ticks_left, chosen_level,
                    output ready);
endinterface

`default_nettype wire

### hdl/mlfq_ctrl.sv
// Sequencer of the scheduler: walks each request through its micro steps.
// Depends on mlfq_pkg; drives the datapath by t_cmd and reads t_stat back.
`default_nettype none

module mlfq_ctrl import mlfq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;
    t_state ret_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctx   <= CTX_ENQ;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
        end
    end

    // where a finished sift goes back to
    always_comb begin
        unique case (r_ctx)
            CTX_ENQ: ret_state = S_RB_NEXT;
            CTX_DEQ: ret_state = S_DQ_RD;
            default: ret_state = S_BST_RD;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ctx   = r_ctx;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                unique case (i_stat.mode)
                    MODE_ADMIT: begin
                        n_ctx   = CTX_ENQ;
                        n_state = i_stat.pid_ok ? S_ADM_WR : S_DONE;
                    end
                    MODE_ENQ: begin
                        n_ctx   = CTX_ENQ;
                        n_state = (i_stat.pid_ok && i_stat.run) ? S_ENQ_RD : S_DONE;
                    end
                    MODE_DEQ: begin
                        n_ctx = CTX_DEQ;
                        if (i_stat.lvl == LVL_HEAP)     n_state = S_HP_A;
                        else if (i_stat.lvl == LVL_0 || i_stat.lvl == LVL_1)
                                                        n_state = S_RP_A;
                        else                            n_state = S_DONE;
                    end
                    default: begin
                        n_ctx   = CTX_B0;
                        n_state = S_B0_A;
                    end
                endcase
            end
            S_ADM_WR:  n_state = S_RB_INIT;
            S_ENQ_RD:  n_state = S_ENQ_WR;
            S_ENQ_WR:  n_state = i_stat.enq_heap ? S_HPUSH : S_RPUSH;
            S_RPUSH: begin
                unique case (r_ctx)
                    CTX_ENQ: n_state = S_RB_INIT;
                    CTX_B1:  n_state = S_RP_A;
                    CTX_B2:  n_state = S_HP_A;
                    default: n_state = S_DONE;
                endcase
            end
            S_HPUSH:   n_state = S_RB_INIT;
            S_RB_INIT: n_state = S_RB_NEXT;
            S_RB_NEXT: n_state = i_stat.rb_zero ? S_DONE : S_SD_CHK;
            S_SD_CHK:  n_state = i_stat.sd_leaf ? ret_state : S_SD_IK;
            S_SD_IK:   n_state = S_SD_L;
            S_SD_L:    n_state = S_SD_LK;
            S_SD_LK:   n_state = S_SD_LC;
            S_SD_LC:   n_state = i_stat.sd_has_r ? S_SD_R : S_SD_X;
            S_SD_R:    n_state = S_SD_RK;
            S_SD_RK:   n_state = S_SD_RC;
            S_SD_RC:   n_state = S_SD_X;
            S_SD_X:    n_state = i_stat.sd_same ? ret_state : S_SD_Y;
            S_SD_Y:    n_state = S_SD_CHK;
            S_HP_A:    n_state = i_stat.heap_empty ? S_DONE : S_HP_B;
            S_HP_B:    n_state = S_HP_C;
            S_HP_C:    n_state = S_SD_CHK;
            S_RP_A: begin
                if (!i_stat.ring_empty[o_cmd.ring]) begin
                    n_state = S_RP_B;
                end else if (r_ctx == CTX_B1) begin
                    n_ctx   = CTX_B2;
                    n_state = S_HP_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RP_B:    n_state = (r_ctx == CTX_DEQ) ? S_DQ_RD : S_BST_RD;
            S_DQ_RD:   n_state = S_DQ_WR;
            S_DQ_WR:   n_state = S_DONE;
            S_B0_A: begin
                if (i_stat.walk_end) begin
                    n_ctx   = CTX_B1;
                    n_state = S_RP_A;
                end else begin
                    n_state = S_B0_B;
                end
            end
            S_B0_B:    n_state = S_BST_RD;
            S_BST_RD:  n_state = S_BST_WR;
            S_BST_WR:  n_state = (r_ctx == CTX_B0) ? S_B0_A : S_RPUSH;
            S_DONE:    if (i_stat.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.ring = (r_ctx == CTX_DEQ) ? i_stat.lvl[0] : 1'b1;
        unique case (r_state)
            S_IDLE:    o_cmd.op = OP_NONE;
            S_DISP:    o_cmd.op = OP_DISP;
            S_ADM_WR:  o_cmd.op = OP_ADM_WR;
            S_ENQ_RD:  o_cmd.op = OP_ENQ_RD;
            S_ENQ_WR:  o_cmd.op = OP_ENQ_WR;
            S_RPUSH:   o_cmd.op = OP_RPUSH;
            S_HPUSH:   o_cmd.op = OP_HPUSH;
            S_RB_INIT: o_cmd.op = OP_RB_INIT;
            S_RB_NEXT: o_cmd.op = OP_RB_NEXT;
            S_SD_CHK:  o_cmd.op = OP_SD_CHK;
            S_SD_IK:   o_cmd.op = OP_SD_IK;
            S_SD_L:    o_cmd.op = OP_SD_L;
            S_SD_LK:   o_cmd.op = OP_SD_LK;
            S_SD_LC:   o_cmd.op = OP_SD_LC;
            S_SD_R:    o_cmd.op = OP_SD_R;
            S_SD_RK:   o_cmd.op = OP_SD_RK;
            S_SD_RC:   o_cmd.op = OP_SD_RC;
            S_SD_X:    o_cmd.op = OP_SD_X;
            S_SD_Y:    o_cmd.op = OP_SD_Y;
            S_HP_A:    o_cmd.op = OP_HP_A;
            S_HP_B:    o_cmd.op = OP_HP_B;
            S_HP_C:    o_cmd.op = OP_HP_C;
            S_RP_A:    o_cmd.op = OP_RP_A;
            S_RP_B:    o_cmd.op = OP_RP_B;
            S_DQ_RD:   o_cmd.op = OP_DQ_RD;
            S_DQ_WR:   o_cmd.op = OP_DQ_WR;
            S_B0_A:    o_cmd.op = OP_B0_A;
            S_B0_B:    o_cmd.op = OP_B0_B;
            S_BST_RD:  o_cmd.op = OP_BST_RD;
            S_BST_WR:  o_cmd.op = OP_BST_WR;
            S_DONE:    o_cmd.op = OP_DONE;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

### hdl/mlfq_dp.sv
// Datapath of the scheduler: process table, two rings, heap and result word.
// Depends on mlfq_pkg; executes one t_cmd step per cycle, reports t_stat.
`default_nettype none

module mlfq_dp import mlfq_pkg::*; #(
    parameter int PROC_SLOTS = PROC_SLOTS_DEF,
    parameter int AGE_WIDTH  = AGE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [ID_W-1:0]   i_proc_id,
    input  wire logic              i_runnable,
    input  wire logic [LVL_W-1:0]  i_level,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_found,
    output logic [ID_W-1:0]        o_chosen_id,
    output logic [QNT_W-1:0]       o_ticks_left,
    output logic [LVL_W-1:0]       o_chosen_level,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat
);

    localparam int IW   = $clog2(PROC_SLOTS);
    localparam int CW   = $clog2(PROC_SLOTS + 1);
    localparam int LW   = CW + 1;
    localparam int RS   = PROC_SLOTS + 1;
    localparam int RIW  = $clog2(RS);
    localparam int RAW  = $clog2(2 * RS);
    localparam int KEYW = PRIO_W + AGE_WIDTH;
    localparam int PW   = LVL_W + QNT_W + KEYW;
    localparam int XW   = (CW > ID_W) ? CW : ID_W;

    function automatic logic [RIW-1:0] f_wrap(input logic [RIW-1:0] x);
        return (x == RIW'(PROC_SLOTS)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [RAW-1:0] f_raddr(input logic sel, input logic [RIW-1:0] x);
        return (sel ? RAW'(RS) : '0) + RAW'(x);
    endfunction

    // a served before b: lower priority value, then larger elapsed count
    function automatic logic f_before(input logic [KEYW-1:0] a, input logic [KEYW-1:0] b);
        logic [PRIO_W-1:0] pa, pb;
        pa = a[KEYW-1 -: PRIO_W];
        pb = b[KEYW-1 -: PRIO_W];
        if (pa != pb) return pa < pb;
        return a[AGE_WIDTH-1:0] > b[AGE_WIDTH-1:0];
    endfunction

    // storage
    logic [PW-1:0]   mem_p [PROC_SLOTS];
    logic [ID_W-1:0] mem_h [PROC_SLOTS];
    logic [ID_W-1:0] mem_r [2*RS];

    logic [PROC_SLOTS-1:0] r_pv;
    logic [PW-1:0]         r_pq;
    logic                  r_pqv;
    logic [ID_W-1:0]       r_hq, r_rq;

    // control registers
    logic [RIW-1:0] r_head0, r_head1, r_tail0, r_tail1;
    logic [CW-1:0]  r_cnt;
    logic           r_ovalid;

    // working registers
    t_mode             r_mode;
    logic [ID_W-1:0]   r_pid, r_wid, r_cid, r_tid, r_bid;
    logic              r_run;
    logic [LVL_W-1:0]  r_lvl;
    logic [PRIO_W-1:0] r_pri;
    logic              r_psel;
    logic [RIW-1:0]    r_walk;
    logic [CW-1:0]     r_bld;
    logic [IW-1:0]     r_i, r_bidx;
    logic [KEYW-1:0]   r_bkey;
    logic              r_res_found;
    logic [ID_W-1:0]   r_res_id;
    logic [QNT_W-1:0]  r_res_ticks;
    logic [LVL_W-1:0]  r_res_lvl;
    logic              r_o_found;
    logic [ID_W-1:0]   r_o_id;
    logic [QNT_W-1:0]  r_o_ticks;
    logic [LVL_W-1:0]  r_o_lvl;

    // decoded record
    logic [PW-1:0]          p_eff;
    logic [LVL_W-1:0]       p_lvl;
    logic [QNT_W-1:0]       p_q;
    logic [PRIO_W-1:0]      p_pr;
    logic [AGE_WIDTH-1:0]   p_age;
    logic [KEYW-1:0]        p_key;

    logic [LVL_W-1:0]       e_lvl;
    logic [QNT_W-1:0]       e_q;
    logic [PRIO_W-1:0]      e_pr;
    logic [AGE_WIDTH-1:0]   e_age;
    logic                   e_heap;
    logic                   e_ring;
    logic [QNT_W-1:0]       q_dec;

    logic [RIW-1:0] ps_head, ps_tail, ps_nt, pp_head;
    logic           ps_full;
    logic [LW-1:0]  l_ext, r_ext, cnt_ext;
    logic           out_free;

    logic              we_p, we_h, we_r;
    logic [IW-1:0]     wa_p, ra_p, wa_h, ra_h;
    logic [PW-1:0]     wd_p;
    logic [ID_W-1:0]   wd_h;
    logic [RAW-1:0]    wa_r, ra_r;

    assign p_eff = r_pqv ? r_pq : '0;
    assign p_lvl = p_eff[PW-1 -: LVL_W];
    assign p_q   = p_eff[PW-LVL_W-1 -: QNT_W];
    assign p_pr  = p_eff[KEYW-1 -: PRIO_W];
    assign p_age = p_eff[AGE_WIDTH-1:0];
    assign p_key = p_eff[KEYW-1:0];

    assign q_dec = (p_q != '0) ? p_q - 1'b1 : p_q;

    always_comb begin
        e_age = '0;
        e_pr  = p_pr;
        e_lvl = p_lvl;
        e_q   = p_q;
        if (p_q == '0) begin
            if (p_lvl == LVL_0) begin
                e_lvl  = LVL_1;
                e_q    = QNT_L1;
                e_heap = 1'b0;
                e_ring = 1'b1;
            end else begin
                if (p_lvl == LVL_HEAP && p_pr != '0) e_pr = p_pr - 1'b1;
                e_lvl  = LVL_HEAP;
                e_q    = QNT_L2;
                e_heap = 1'b1;
                e_ring = 1'b0;
            end
        end else begin
            e_age  = (p_age == '1) ? p_age : p_age + 1'b1;
            e_heap = (p_lvl >= LVL_HEAP);
            e_ring = p_lvl[0];
        end
    end

    assign ps_head = r_psel ? r_head1 : r_head0;
    assign ps_tail = r_psel ? r_tail1 : r_tail0;
    assign ps_nt   = f_wrap(ps_tail);
    assign ps_full = (ps_nt == ps_head);
    assign pp_head = i_cmd.ring ? r_head1 : r_head0;

    assign l_ext   = LW'({r_i, 1'b1});
    assign r_ext   = l_ext + LW'(1);
    assign cnt_ext = LW'(r_cnt);
    assign out_free = !r_ovalid || i_out_ready;

    // memory addressing
    always_comb begin
        we_p = 1'b0;
        wa_p = IW'(r_wid);
        wd_p = '0;
        ra_p = IW'(r_hq);
        we_h = 1'b0;
        wa_h = r_i;
        wd_h = r_bid;
        ra_h = r_i;
        we_r = 1'b0;
        wa_r = f_raddr(r_psel, ps_tail);
        ra_r = f_raddr(i_cmd.ring, pp_head);
        unique case (i_cmd.op)
            OP_ADM_WR: begin
                we_p = 1'b1;
                wa_p = IW'(r_pid);
                wd_p = {LVL_0, QNT_L0, r_pri, {AGE_WIDTH{1'b0}}};
            end
            OP_ENQ_RD: ra_p = IW'(r_pid);
            OP_ENQ_WR: begin
                we_p = 1'b1;
                wa_p = IW'(r_pid);
                wd_p = {e_lvl, e_q, e_pr, e_age};
            end
            OP_RPUSH:  we_r = !ps_full;
            OP_HPUSH: begin
                we_h = (r_cnt < CW'(PROC_SLOTS));
                wa_h = IW'(r_cnt);
                wd_h = r_wid;
            end
            OP_SD_L:   ra_h = IW'(l_ext);
            OP_SD_R:   ra_h = IW'(r_ext);
            OP_SD_X:   we_h = (r_bidx != r_i);
            OP_SD_Y: begin
                we_h = 1'b1;
                wa_h = r_bidx;
                wd_h = r_cid;
            end
            OP_HP_A:   ra_h = '0;
            OP_HP_B:   ra_h = IW'(r_cnt - 1'b1);
            OP_HP_C: begin
                we_h = 1'b1;
                wa_h = '0;
                wd_h = r_hq;
            end
            OP_DQ_RD, OP_BST_RD: ra_p = IW'(r_wid);
            OP_DQ_WR: begin
                we_p = 1'b1;
                wd_p = {p_lvl, q_dec, p_key};
            end
            OP_BST_WR: begin
                we_p = 1'b1;
                wd_p = {LVL_0, QNT_L0, p_key};
            end
            OP_B0_A:   ra_r = f_raddr(1'b0, r_walk);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_p) mem_p[wa_p] <= wd_p;
        if (we_h) mem_h[wa_h] <= wd_h;
        if (we_r) mem_r[wa_r] <= r_wid;
        r_pq  <= mem_p[ra_p];
        r_pqv <= r_pv[ra_p];
        r_hq  <= mem_h[ra_h];
        r_rq  <= mem_r[ra_r];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= '0;
            r_head0  <= '0;
            r_head1  <= '0;
            r_tail0  <= '0;
            r_tail1  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (we_p) r_pv[wa_p] <= 1'b1;
            if (i_cmd.op == OP_RP_B) begin
                if (i_cmd.ring) r_head1 <= f_wrap(r_head1);
                else            r_head0 <= f_wrap(r_head0);
            end
            if (i_cmd.op == OP_RPUSH && !ps_full) begin
                if (r_psel) r_tail1 <= ps_nt;
                else        r_tail0 <= ps_nt;
            end
            if (i_cmd.op == OP_HPUSH && r_cnt < CW'(PROC_SLOTS)) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.op == OP_HP_B) r_cnt <= r_cnt - 1'b1;
            if (i_cmd.op == OP_DONE && out_free) r_ovalid <= 1'b1;
            else if (i_out_ready)                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mode      <= t_mode'(i_mode);
            r_pid       <= i_proc_id;
            r_run       <= i_runnable;
            r_lvl       <= i_level;
            r_pri       <= i_priority_req;
            r_res_found <= 1'b0;
            r_res_id    <= '0;
            r_res_ticks <= '0;
            r_res_lvl   <= '0;
        end
        unique case (i_cmd.op)
            OP_DISP:    r_walk <= r_head0;
            OP_ENQ_WR: begin
                r_wid  <= r_pid;
                r_psel <= e_ring;
            end
            OP_RB_INIT: r_bld <= r_cnt >> 1;
            OP_RB_NEXT: begin
                if (r_bld != '0) begin
                    r_bld <= r_bld - 1'b1;
                    r_i   <= IW'(r_bld - 1'b1);
                end
            end
            OP_SD_IK:   r_cid <= r_hq;
            OP_SD_L: begin
                r_bidx <= r_i;
                r_bid  <= r_cid;
                r_bkey <= p_key;
            end
            OP_SD_LK, OP_SD_RK: r_tid <= r_hq;
            OP_SD_LC: begin
                if (f_before(p_key, r_bkey)) begin
                    r_bidx <= IW'(l_ext);
                    r_bid  <= r_tid;
                    r_bkey <= p_key;
                end
            end
            OP_SD_RC: begin
                if (f_before(p_key, r_bkey)) begin
                    r_bidx <= IW'(r_ext);
                    r_bid  <= r_tid;
                    r_bkey <= p_key;
                end
            end
            OP_SD_Y:    r_i <= r_bidx;
            OP_HP_B:    r_wid <= r_hq;
            OP_HP_C:    r_i <= '0;
            OP_RP_B:    r_wid <= r_rq;
            OP_B0_B: begin
                r_wid  <= r_rq;
                r_walk <= f_wrap(r_walk);
            end
            OP_DQ_WR: begin
                r_res_found <= 1'b1;
                r_res_id    <= r_wid;
                r_res_ticks <= q_dec;
                r_res_lvl   <= p_lvl;
            end
            OP_BST_WR:  r_psel <= 1'b0;
            OP_DONE: begin
                if (out_free) begin
                    r_o_found <= r_res_found;
                    r_o_id    <= r_res_id;
                    r_o_ticks <= r_res_ticks;
                    r_o_lvl   <= r_res_lvl;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.pid_ok     = XW'(r_pid) < XW'(PROC_SLOTS);
        o_stat.run        = r_run;
        o_stat.lvl        = r_lvl;
        o_stat.enq_heap   = e_heap;
        o_stat.ring_empty = {r_head1 == r_tail1, r_head0 == r_tail0};
        o_stat.heap_empty = (r_cnt == '0);
        o_stat.sd_leaf    = (l_ext >= cnt_ext);
        o_stat.sd_has_r   = (r_ext < cnt_ext);
        o_stat.sd_same    = (r_bidx == r_i);
        o_stat.rb_zero    = (r_bld == '0);
        o_stat.walk_end   = (r_walk == r_tail0);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid    = r_ovalid;
    assign o_found        = r_o_found;
    assign o_chosen_id    = r_o_id;
    assign o_ticks_left   = r_o_ticks;
    assign o_chosen_level = r_o_lvl;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(PROC_SLOTS))
        else $error("heap count beyond capacity");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_o_found) |-> (r_o_id == '0 && r_o_ticks == '0 && r_o_lvl == '0))
        else $error("empty result word carries data");

    a_ticks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_found) |-> (r_o_ticks < QNT_L2 && r_o_lvl <= LVL_HEAP))
        else $error("result quantum or level out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_HP_B) |-> (r_cnt != '0))
        else $error("heap pop on empty heap");

endmodule

`default_nettype wire

### hdl/mlfq_process_scheduler_top.sv
// Top level of the multilevel feedback scheduler: sequencer plus datapath.
// Depends on mlfq_pkg, mlfq_in_if, mlfq_out_if, mlfq_ctrl and mlfq_dp.
//
// Usage:
//   i_in carries one request word per handshake (mode, proc_id, runnable,
//   level, priority_req); o_out returns exactly one result word per request.
//   Requests are taken one at a time: i_in.ready is high only while the
//   sequencer is idle. A result sits in an output register, so the next
//   request is accepted while an earlier result waits for o_out.ready; the
//   sequencer only stalls at its final step if that register is still full.
//   A dequeue from the heap ends with one sift; boost takes one sift per
//   heap entry. Admit and enqueue end with a heap rebuild: count/2 sifts,
//   each preceded by one step. A sift stops at a leaf or once the node
//   settles, and descends up to log2(PROC_SLOTS) levels. The heap and
//   process memories each have a single read port, so a sift reads the
//   node and its children one after another.
//   Reset (synchronous, active low) empties both rings and the heap and
//   returns every process record to zero; no clearing pass is needed.
`default_nettype none

module mlfq_process_scheduler_top import mlfq_pkg::*; #(
    parameter int PROC_SLOTS = PROC_SLOTS_DEF,
    parameter int AGE_WIDTH  = AGE_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mlfq_in_if.sink   i_in,
    mlfq_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mlfq_dp #(
        .PROC_SLOTS (PROC_SLOTS),
        .AGE_WIDTH  (AGE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (i_in.valid && in_ready),
        .i_mode         (i_in.mode),
        .i_proc_id      (i_in.proc_id),
        .i_runnable     (i_in.runnable),
        .i_level        (i_in.level),
        .i_priority_req (i_in.priority_req),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_found        (o_out.found),
        .o_chosen_id    (o_out.chosen_id),
        .o_ticks_left   (o_out.ticks_left),
        .o_chosen_level (o_out.chosen_level),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking bench for mlfq_process_scheduler_top: a request driver, a
// result monitor and a behavioral scheduler that predicts each result word.
// Depends on mlfq_pkg, mlfq_in_if, mlfq_out_if and the scheduler RTL.
`timescale 1ns / 1ps

module tb_top import mlfq_pkg::*;;

    localparam int NSLOT = 64;
    localparam int RSZ   = NSLOT + 1;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   pid;
        logic              run;
        logic [LVL_W-1:0]  lvl;
        logic [PRIO_W-1:0] pri;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [ID_W-1:0]  id;
        logic [QNT_W-1:0] ticks;
        logic [LVL_W-1:0] lvl;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    mlfq_in_if  req_if ();
    mlfq_out_if res_if ();

    mlfq_process_scheduler_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if.sink),
        .o_out  (res_if.source)
    );

    // scheduler shadow state
    logic [LVL_W-1:0]  p_lvl [NSLOT];
    logic [QNT_W-1:0]  p_qnt [NSLOT];
    logic [PRIO_W-1:0] p_pri [NSLOT];
    logic [15:0]       p_age [NSLOT];
    logic [ID_W-1:0]   rq [2][RSZ];
    int rhd [2];
    int rtl [2];
    logic [ID_W-1:0]   hp [NSLOT];
    int hcnt;

    t_req pending_reqs [$];
    t_res expected_res [$];
    int   n_err = 0;
    bit   quiet = 0;   // no idling while set

    function automatic bit rq_push(int r, logic [ID_W-1:0] id);
        int nt;
        nt = (rtl[r] + 1) % RSZ;
        if (nt == rhd[r]) return 0;
        rq[r][rtl[r]] = id;
        rtl[r] = nt;
        return 1;
    endfunction

    function automatic bit rq_pop(int r, output logic [ID_W-1:0] id);
        id = '0;
        if (rhd[r] == rtl[r]) return 0;
        id = rq[r][rhd[r]];
        rhd[r] = (rhd[r] + 1) % RSZ;
        return 1;
    endfunction

    function automatic bit runs_first(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        if (p_pri[a] != p_pri[b]) return p_pri[a] < p_pri[b];
        return p_age[a] > p_age[b];
    endfunction

    function automatic void sift(int i);
        int best, l, r;
        logic [ID_W-1:0] t;
        forever begin
            best = i; l = 2 * i + 1; r = 2 * i + 2;
            if (l < hcnt && runs_first(hp[l], hp[best])) best = l;
            if (r < hcnt && runs_first(hp[r], hp[best])) best = r;
            if (best == i) return;
            t = hp[i]; hp[i] = hp[best]; hp[best] = t;
            i = best;
        end
    endfunction

    function automatic void reheap();
        for (int i = hcnt / 2 - 1; i >= 0; i--) sift(i);
    endfunction

    function automatic void hp_push(logic [ID_W-1:0] id);
        if (hcnt < NSLOT) begin
            hp[hcnt] = id;
            hcnt++;
        end
        reheap();
    endfunction

    function automatic bit hp_pop(output logic [ID_W-1:0] id);
        id = '0;
        if (hcnt == 0) return 0;
        id = hp[0];
        hcnt--;
        hp[0] = hp[hcnt];
        sift(0);
        return 1;
    endfunction

    function automatic void to_l0(logic [ID_W-1:0] id);
        p_lvl[id] = LVL_0;
        p_qnt[id] = QNT_L0;
        void'(rq_push(0, id));
    endfunction

    function automatic void reset_sched();
        for (int i = 0; i < NSLOT; i++) begin
            p_lvl[i] = '0; p_qnt[i] = '0; p_pri[i] = '0; p_age[i] = '0;
        end
        rhd = '{0, 0}; rtl = '{0, 0}; hcnt = 0;
    endfunction

    function automatic t_res schedule(t_req q);
        t_res o;
        logic [ID_W-1:0] id;
        int n;
        o = '0;
        id = q.pid;
        case (q.mode)
            MODE_ADMIT: begin
                p_lvl[id] = LVL_0; p_qnt[id] = QNT_L0;
                p_age[id] = '0;    p_pri[id] = q.pri;
                reheap();
            end
            MODE_ENQ: if (q.run) begin
                if (p_qnt[id] == 0) begin
                    // demote on an expired quantum
                    p_age[id] = '0;
                    if (p_lvl[id] == LVL_0) begin
                        p_lvl[id] = LVL_1; p_qnt[id] = QNT_L1;
                        void'(rq_push(1, id));
                        reheap();
                    end else begin
                        if (p_lvl[id] == LVL_HEAP && p_pri[id] != 0) p_pri[id]--;
                        p_lvl[id] = LVL_HEAP; p_qnt[id] = QNT_L2;
                        hp_push(id);
                    end
                end else begin
                    if (p_age[id] < AGE_MAX) p_age[id]++;
                    if (p_lvl[id] >= LVL_HEAP) hp_push(id);
                    else begin
                        void'(rq_push(p_lvl[id], id));
                        reheap();
                    end
                end
            end
            MODE_DEQ: begin
                if (q.lvl == LVL_HEAP) o.found = hp_pop(id);
                else if (q.lvl < LVL_HEAP) o.found = rq_pop(q.lvl, id);
                if (o.found) begin
                    if (p_qnt[id] != 0) p_qnt[id]--;
                    o.id = id; o.ticks = p_qnt[id]; o.lvl = p_lvl[id];
                end
            end
            default: begin
                n = (rtl[0] + RSZ - rhd[0]) % RSZ;
                for (int k = 0; k < n; k++) if (rq_pop(0, id)) to_l0(id);
                while (rq_pop(1, id)) to_l0(id);
                while (hp_pop(id)) to_l0(id);
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        n_err++;
    endtask

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 9);
    endfunction

    // request driver; predict each result word at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_res.push_back(schedule(pending_reqs[0]));
                pending_reqs.pop_front();
            end
            if (pending_reqs.size() > 0 && !idle_now()
                && !(req_if.valid && !req_if.ready) ) begin
                req_if.valid        <= 1'b1;
                req_if.mode         <= pending_reqs[0].mode;
                req_if.proc_id      <= pending_reqs[0].pid;
                req_if.runnable     <= pending_reqs[0].run;
                req_if.level        <= pending_reqs[0].lvl;
                req_if.priority_req <= pending_reqs[0].pri;
            end else if (!(req_if.valid && !req_if.ready)) begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !idle_now();
            if (res_if.valid && res_if.ready) begin
                if (expected_res.size() == 0) begin
                    report_mismatch("unexpected word", res_if.chosen_id, -1);
                end else begin
                    want = expected_res.pop_front();
                    if (res_if.found != want.found)
                        report_mismatch("found", res_if.found, want.found);
                    if (res_if.chosen_id != want.id)
                        report_mismatch("chosen_id", res_if.chosen_id, want.id);
                    if (res_if.ticks_left != want.ticks)
                        report_mismatch("ticks_left", res_if.ticks_left, want.ticks);
                    if (res_if.chosen_level != want.lvl)
                        report_mismatch("chosen_level", res_if.chosen_level, want.lvl);
                end
            end
        end
    end

    function automatic t_req mk(t_mode m, int pid, bit run, int lvl, int pri);
        t_req q;
        q.mode = m;
        q.pid  = ID_W'(pid);
        q.run  = run;
        q.lvl  = LVL_W'(lvl);
        q.pri  = PRIO_W'(pri);
        return q;
    endfunction

    function automatic t_req rnd_req(int npid);
        int sel;
        t_req q;
        sel = $urandom_range(99);
        q = mk(MODE_ENQ, $urandom_range(npid - 1), 1'b1, $urandom_range(2),
               $urandom_range(15));
        if (sel < 15) q.mode = MODE_ADMIT;
        else if (sel < 55) q.mode = MODE_ENQ;
        else if (sel < 95) q.mode = MODE_DEQ;
        else q.mode = MODE_BOOST;
        if ($urandom_range(19) == 0) q.run = 1'b0;
        if ($urandom_range(29) == 0) q.lvl = '1;   // level with no queue
        if ($urandom_range(9) == 0) q.pid = ID_W'($urandom_range(63));
        return q;
    endfunction

    initial begin
        int npid;
        req_if.valid = 1'b0; req_if.mode = '0; req_if.proc_id = '0;
        req_if.runnable = 1'b0; req_if.level = '0; req_if.priority_req = '0;
        res_if.ready = 1'b0;
        reset_sched();
        // directed: empty dequeues, field extremes, demotion from level 0 to level 1
        pending_reqs.push_back(mk(MODE_DEQ, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_DEQ, 0, 0, 2, 0));
        pending_reqs.push_back(mk(MODE_DEQ, 63, 1, 3, 15));
        pending_reqs.push_back(mk(MODE_ADMIT, 63, 1, 0, 15));
        pending_reqs.push_back(mk(MODE_ADMIT, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_ENQ, 63, 0, 0, 0));
        for (int i = 0; i < 4; i++) begin
            pending_reqs.push_back(mk(MODE_ENQ, 63, 1, 0, 0));
            pending_reqs.push_back(mk(MODE_DEQ, 0, 0, 0, 0));
        end
        pending_reqs.push_back(mk(MODE_ENQ, 63, 1, 0, 0));  // to level 1
        pending_reqs.push_back(mk(MODE_DEQ, 0, 0, 1, 0));
        pending_reqs.push_back(mk(MODE_ENQ, 0, 1, 0, 0));
        pending_reqs.push_back(mk(MODE_BOOST, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_DEQ, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_DEQ, 0, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_ENQ, 0, 1, 0, 0));   // slot 0, admitted earlier
        pending_reqs.push_back(mk(MODE_ENQ, 0, 1, 0, 0));
        pending_reqs.push_back(mk(MODE_DEQ, 0, 0, 2, 0));
        // random: small pid pools keep processes cycling through the levels
        for (int i = 0; i < 550; i++) begin
            npid = (i < 400) ? 8 : 64;
            pending_reqs.push_back(rnd_req(npid));
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // no-idling stretch in the middle of the run
    initial begin
        wait (i_rst_n);
        wait (pending_reqs.size() < 300);
        quiet = 1;
        wait (pending_reqs.size() < 200);
        quiet = 0;
    end

    initial begin
        wait (i_rst_n);
        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_err == 0 && expected_res.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL");
        $finish;
    end
endmodule
